>>> rtl/core/a51_pkg.sv
// Shared types and constants for the A5/1 keystream generator.
package a51_pkg;

  localparam int unsigned CNT_W = 7;

  localparam logic [CNT_W-1:0] INIT_LAST  = CNT_W'(64 + 22 - 1);
  localparam logic [CNT_W-1:0] MIX_LAST   = CNT_W'(100 - 1);
  localparam logic [CNT_W-1:0] BURST_LAST = CNT_W'(114 - 1);

  localparam int unsigned SEED_W = 64 + 22;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_MIX  = 4'b0100,
    S_GEN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic       load;     // clear LFSRs, latch key and frame
    logic       mix;      // clock all three, xor in next seed bit
    logic       maj;      // majority clock
    logic       pack;     // shift output bit into assembler
    logic       emit;     // load output register
    logic       partial;  // two-bit closing byte of a burst
    logic       burst;
    logic [3:0] idx;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic out_room;       // output register free or draining this cycle
  } status_t;

endpackage

>>> rtl/core/a51_datapath.sv
// LFSRs, seed shifter, byte assembler and output register.
module a51_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  logic [21:0]        frame_number,
  input  a51_pkg::cmd_t      cmd,
  output a51_pkg::status_t   status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         keystream_byte,
  output logic               burst_select,
  output logic [3:0]         byte_index,
  output logic               last_byte
);

  logic [63:0]                  session_key;
  logic [a51_pkg::SEED_W-1:0]   seed;
  logic [18:0]                  lfsr_one,   lfsr_one_next,   sh1;
  logic [21:0]                  lfsr_two,   lfsr_two_next,   sh2;
  logic [22:0]                  lfsr_three, lfsr_three_next, sh3;
  logic [6:0]                   byte_assembler;
  logic                         c1, c2, c3, maj, obit;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_key <= '0;
    end else if (cfg_we) begin
      session_key <= cfg_wdata;
    end
  end

  always_comb begin
    sh1 = {lfsr_one[17:0],   lfsr_one[18] ^ lfsr_one[17] ^ lfsr_one[16] ^ lfsr_one[13]};
    sh2 = {lfsr_two[20:0],   lfsr_two[21] ^ lfsr_two[20]};
    sh3 = {lfsr_three[21:0],
           lfsr_three[22] ^ lfsr_three[21] ^ lfsr_three[20] ^ lfsr_three[7]};
    c1  = lfsr_one[8];
    c2  = lfsr_two[10];
    c3  = lfsr_three[10];
    maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

    lfsr_one_next   = lfsr_one;
    lfsr_two_next   = lfsr_two;
    lfsr_three_next = lfsr_three;
    if (cmd.load) begin
      lfsr_one_next   = '0;
      lfsr_two_next   = '0;
      lfsr_three_next = '0;
    end else if (cmd.mix) begin
      lfsr_one_next   = sh1 ^ {18'b0, seed[0]};
      lfsr_two_next   = sh2 ^ {21'b0, seed[0]};
      lfsr_three_next = sh3 ^ {22'b0, seed[0]};
    end else if (cmd.maj) begin
      if (c1 == maj) lfsr_one_next   = sh1;
      if (c2 == maj) lfsr_two_next   = sh2;
      if (c3 == maj) lfsr_three_next = sh3;
    end
    // keystream bit is taken after the clock
    obit = lfsr_one_next[18] ^ lfsr_two_next[21] ^ lfsr_three_next[22];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_one       <= '0;
      lfsr_two       <= '0;
      lfsr_three     <= '0;
      byte_assembler <= '0;
    end else begin
      lfsr_one   <= lfsr_one_next;
      lfsr_two   <= lfsr_two_next;
      lfsr_three <= lfsr_three_next;
      if (cmd.pack) begin
        byte_assembler <= {byte_assembler[5:0], obit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seed <= {frame_number, session_key};
    end else if (cmd.mix) begin
      seed <= seed >> 1;
    end
    if (cmd.emit) begin
      keystream_byte <= cmd.partial ? {byte_assembler[0], obit, 6'b0}
                                    : {byte_assembler, obit};
      burst_select   <= cmd.burst;
      byte_index     <= cmd.idx;
      last_byte      <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_room = !out_valid || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("beat overwritten before it was taken");

endmodule

>>> rtl/core/a51_ctrl.sv
// Sequencer for key/frame loading, warm-up and keystream bursts.
module a51_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  a51_pkg::status_t   status,
  output a51_pkg::cmd_t      cmd
);

  a51_pkg::state_t               state, state_next;
  logic [a51_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic                          burst, burst_next;
  logic                          start, gen_go, burst_end;

  assign in_ready  = (state == a51_pkg::S_IDLE);
  assign start     = in_valid && in_ready;
  assign gen_go    = (state == a51_pkg::S_GEN) && status.out_room;
  assign burst_end = (cnt == a51_pkg::BURST_LAST);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    burst_next = burst;
    unique case (state)
      a51_pkg::S_IDLE: begin
        if (start) begin
          state_next = a51_pkg::S_INIT;
          cnt_next   = '0;
        end
      end
      a51_pkg::S_INIT: begin
        if (cnt == a51_pkg::INIT_LAST) begin
          state_next = a51_pkg::S_MIX;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      a51_pkg::S_MIX: begin
        if (cnt == a51_pkg::MIX_LAST) begin
          state_next = a51_pkg::S_GEN;
          cnt_next   = '0;
          burst_next = 1'b0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      a51_pkg::S_GEN: begin
        if (gen_go) begin
          if (burst_end) begin
            cnt_next   = '0;
            burst_next = 1'b1;
            if (burst) state_next = a51_pkg::S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = a51_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= a51_pkg::S_IDLE;
      cnt   <= '0;
      burst <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      burst <= burst_next;
    end
  end

  always_comb begin
    cmd.load    = start;
    cmd.mix     = (state == a51_pkg::S_INIT);
    cmd.maj     = (state == a51_pkg::S_MIX) || gen_go;
    cmd.pack    = gen_go;
    // a byte closes every eighth bit and at the end of the burst
    cmd.emit    = gen_go && ((cnt[2:0] == 3'b111) || burst_end);
    cmd.partial = burst_end;
    cmd.burst   = burst;
    cmd.idx     = cnt[6:3];
    cmd.last    = burst && burst_end;
  end

  a_gen_bound: assert property (@(posedge clk) disable iff (rst)
    (state == a51_pkg::S_GEN) |-> (cnt <= a51_pkg::BURST_LAST))
    else $error("bit counter ran past the burst");

  a_start_init: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == a51_pkg::S_INIT) && (cnt == '0))
    else $error("accepted frame did not start loading");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == a51_pkg::S_IDLE))
    else $error("sequencer did not return to idle after last beat");

endmodule

>>> rtl/core/a51_keystream_generator_core.sv
// A5/1 keystream generator: top level joining sequencer and datapath.
// The first beat shows on m_tvalid once the frame is taken and the LFSRs have run the key/frame
// loading, the warm-up and the keystream clocks of the first byte; the last of these loads the beat.
// Throughput: one LFSR clock per cycle while a frame runs, held while a beat waits on m_tready;
// a new frame is taken only in idle, after both bursts of the previous one.
// Reset (rst, synchronous, active high) clears the key, the LFSRs, the sequencer and m_tvalid.
module a51_keystream_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,     // session_key
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,       // [21:0] frame_number, [23:22] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [7:0] keystream_byte, [11:8] byte_index, [15:12] zero
  output logic        m_tuser,       // [0] burst_select
  output logic        m_tlast        // last_byte
);

  a51_pkg::cmd_t    cmd;
  a51_pkg::status_t status;
  logic [7:0]       keystream_byte;
  logic [3:0]       byte_index;

  a51_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  a51_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .frame_number   (s_tdata[21:0]),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .keystream_byte (keystream_byte),
    .burst_select   (m_tuser),
    .byte_index     (byte_index),
    .last_byte      (m_tlast)
  );

  assign m_tdata = {4'b0, byte_index, keystream_byte};

endmodule

>>> tb/a51_keystream_generator_core_tb.sv
// Self-checking testbench for the A5/1 keystream generator core.
`timescale 1ns / 100ps

module a51_keystream_generator_core_tb;

  localparam int KEY_BITS    = 64;
  localparam int FRAME_BITS  = 22;
  localparam int WARMUP      = 100;
  localparam int BURST_BITS  = 114;
  localparam int BURST_BYTES = 15;
  localparam int SETTLE      = 200;
  localparam int LIMIT       = 1000000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] ks_byte;
    logic       burst;
    logic [3:0] idx;
    logic       last;
  } ks_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;       // [21:0] frame_number, [23:22] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [7:0] keystream_byte, [11:8] byte_index, [15:12] zero
  logic        m_tuser;            // [0] burst_select
  logic        m_tlast;

  logic [21:0] frames_to_send[$];
  ks_beat_t    keystream_due[$];
  logic [63:0] key_shadow = '0;
  logic        frame_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          rx_hold_len = 0;
  int          rx_hold_seq = 0;
  int          mismatches = 0;
  int          cycles = 0;

  a51_keystream_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [18:0] shift_r1(input logic [18:0] r);
    return {r[17:0], r[18] ^ r[17] ^ r[16] ^ r[13]};
  endfunction

  function automatic logic [21:0] shift_r2(input logic [21:0] r);
    return {r[20:0], r[21] ^ r[20]};
  endfunction

  function automatic logic [22:0] shift_r3(input logic [22:0] r);
    return {r[21:0], r[22] ^ r[21] ^ r[20] ^ r[7]};
  endfunction

  // Advance each register whose clocking bit agrees with the majority.
  function automatic void clock_majority(inout logic [18:0] r1, inout logic [21:0] r2,
                                         inout logic [22:0] r3);
    logic maj;
    maj = (r1[8] & r2[10]) | (r1[8] & r3[10]) | (r2[10] & r3[10]);
    if (r1[8] == maj) r1 = shift_r1(r1);
    if (r2[10] == maj) r2 = shift_r2(r2);
    if (r3[10] == maj) r3 = shift_r3(r3);
  endfunction

  function automatic void predict_keystream(input logic [21:0] frame);
    logic [18:0] r1;
    logic [21:0] r2;
    logic [22:0] r3;
    logic        seed_bit;
    logic [7:0]  acc;
    ks_beat_t    beat;
    int          n;
    int          burst;
    r1 = '0;
    r2 = '0;
    r3 = '0;
    for (n = 0; n < KEY_BITS + FRAME_BITS; n++) begin
      seed_bit = (n < KEY_BITS) ? key_shadow[n] : frame[n - KEY_BITS];
      r1 = shift_r1(r1) ^ 19'(seed_bit);
      r2 = shift_r2(r2) ^ 22'(seed_bit);
      r3 = shift_r3(r3) ^ 23'(seed_bit);
    end
    for (n = 0; n < WARMUP; n++)
      clock_majority(r1, r2, r3);
    for (burst = 0; burst < 2; burst++) begin
      acc = '0;
      for (n = 0; n < BURST_BITS; n++) begin
        clock_majority(r1, r2, r3);
        acc[7 - (n % 8)] = r1[18] ^ r2[21] ^ r3[22];
        if (n % 8 == 7 || n == BURST_BITS - 1) begin
          beat.ks_byte = acc;
          beat.burst   = burst[0];
          beat.idx     = 4'(n / 8);
          beat.last    = (burst == 1) && (n / 8 == BURST_BYTES - 1);
          keystream_due.push_back(beat);
          acc = '0;
        end
      end
    end
  endfunction

  // Frame driver: present the next pending frame once the slot is free.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || frame_taken) begin
      if (frames_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= {2'b00, frames_to_send.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Keystream sink: random stalls, plus long hold-offs on request.
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_hold_seq != hold_seen) begin
        hold_seen = rx_hold_seq;
        hold_left = rx_hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: predict on every frame beat, check every keystream beat.
  always @(posedge clk) begin
    ks_beat_t want;
    ks_beat_t got;
    if (rst) begin
      frame_taken <= 1'b0;
    end else begin
      frame_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        predict_keystream(s_tdata[21:0]);
      if (m_tvalid && m_tready) begin
        got = '{ks_byte: m_tdata[7:0], burst: m_tuser, idx: m_tdata[11:8], last: m_tlast};
        if (keystream_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected beat byte=%h burst=%0d idx=%0d last=%0d",
                     $realtime, got.ks_byte, got.burst, got.idx, got.last);
        end else begin
          want = keystream_due.pop_front();
          if (got !== want || m_tdata[15:12] !== 4'h0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: beat mismatch exp byte=%h burst=%0d idx=%0d last=%0d | %s%h %s%0d %s%0d %s%0d",
                       $realtime, want.ks_byte, want.burst, want.idx, want.last,
                       "got byte=", got.ks_byte, "burst=", got.burst,
                       "idx=", got.idx, "last=", got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("FAIL a51_keystream_generator_core");
      $finish;
    end
  end

  // Hold until nothing is queued, offered or owed, then let the core settle.
  task automatic wait_drained();
    @(posedge clk);
    while (frames_to_send.size() > 0 || s_tvalid || keystream_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] key);
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= key;
    key_shadow  = key;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic random_frames(input int count);
    repeat (count) frames_to_send.push_back(22'($urandom));
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset key first, then the extremes and a known key.
    set_idling(0, 0);
    frames_to_send.push_back(22'h000000);
    frames_to_send.push_back(22'h3FFFFF);
    wait_drained();

    load_key(64'hFFFF_FFFF_FFFF_FFFF);
    frames_to_send.push_back(22'h000000);
    frames_to_send.push_back(22'h3FFFFF);
    frames_to_send.push_back(22'h155555);
    frames_to_send.push_back(22'h2AAAAA);
    wait_drained();

    load_key(64'hEFCD_AB89_6745_2312);
    frames_to_send.push_back(22'h000134);
    frames_to_send.push_back(22'h000134);  // same frame twice: no carry-over
    frames_to_send.push_back(22'h000001);
    frames_to_send.push_back(22'h200000);
    wait_drained();

    load_key(64'h0000_0000_0000_0000);
    frames_to_send.push_back(22'h2AAAAA);
    frames_to_send.push_back(22'h000134);
    wait_drained();

    load_key(64'h8000_0000_0000_0001);
    frames_to_send.push_back(22'h3FFFFF);
    frames_to_send.push_back(22'h155555);
    wait_drained();

    // Back-pressure: stall the sink long enough for the input to block.
    load_key({$urandom, $urandom});
    random_frames(3);
    rx_hold_len = 1500;
    rx_hold_seq++;
    wait_drained();

    load_key({$urandom, $urandom});
    set_idling(0, 0);
    random_frames(42);
    wait_drained();

    load_key({$urandom, $urandom});
    set_idling(81, 0);
    random_frames(42);
    wait_drained();

    load_key({$urandom, $urandom});
    set_idling(0, 81);
    random_frames(42);
    wait_drained();

    load_key(64'h5555_5555_5555_5555);
    set_idling(32, 32);
    random_frames(21);
    wait_drained();

    load_key(64'hAAAA_AAAA_AAAA_AAAA);
    random_frames(21);
    wait_drained();

    if (mismatches == 0)
      $display("PASS a51_keystream_generator_core");
    else
      $display("FAIL a51_keystream_generator_core");
    $finish;
  end

endmodule
